### sv/btq_pkg.sv
`timescale 1ns / 1ps
// Package for the block table quantizer: payload structs, codes, the reset
// divisor table and shared constants. Used by the divider and the top module.
package btq_pkg;

    // Default line limit in 8-pixel blocks
    localparam int DEF_MAX_LINE_BLOCKS = 512;
    // Frame height limit in 8-line blocks (fixed)
    localparam int MAX_FRAME_BLOCKS    = 512;
    localparam int ROW_W               = 12;
    localparam int CFG_W               = 10;
    localparam int CFG_IDX_W           = 1;

    localparam int TBL_DEPTH           = 64;
    localparam int TBL_AW              = 6;
    localparam int Q_W                 = 8;
    localparam int PIX_W               = 8;
    localparam int DVD_W               = 9;
    localparam int DIV_STEPS           = DVD_W;
    localparam int DIV_CNT_W           = 4;

    // Input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel;
        logic [5:0]       entry_index;
        logic [7:0]       entry_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] quantized;
        logic       end_of_line;
        logic       end_of_frame;
    } t_out_item;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Standard luminance table, row-major
    localparam logic [Q_W-1:0] LUMA_TABLE [TBL_DEPTH] = '{
        8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
        8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
        8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
        8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
        8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
        8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
        8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
        8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
    };

endpackage

### sv/btq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/btq_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, 9-bit dividend,
// 8-bit divisor. Depends on btq_pkg.
module btq_div import btq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [Q_W-1:0]   i_divisor,
    output t_div_status      o_status,
    output logic [Q_W-1:0]   o_quotient
);

    logic [DVD_W-1:0]     r_dvd;   // dividend bits out, quotient bits in
    logic [Q_W-1:0]       r_rem;
    logic [Q_W-1:0]       r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DVD_W-1:0]     trial;
    logic                 ge;
    logic [DVD_W-1:0]     diff;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        ge    = trial >= {1'b0, r_q};
        diff  = trial - {1'b0, r_q};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_q   <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            // remainder stays below the divisor, so 8 bits hold it
            r_rem <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    // quotient never exceeds 255
    assign o_quotient    = r_dvd[Q_W-1:0];

endmodule

### sv/block_table_quantizer.sv
`timescale 1ns / 1ps
// Block table quantizer: per-pixel divide by an 8x8 table entry, rounded half up.
// Each pixel passes through table read, bit-serial divide, done handoff and
// output load. The next transfer is taken only after the result is loaded
// into the output register, so a new pixel waits for the last; stalls delay it.
// Table loads give no result and do not leave the idle state.
// Reset (synchronous, active low) restores the luminance table through per-entry
// valid bits, zeroes column and row, and sets both geometry registers to 32.
module block_table_quantizer import btq_pkg::*; #(
    parameter int MAX_LINE_BLOCKS = DEF_MAX_LINE_BLOCKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_LINE_BLOCKS * 8);
    localparam int MLB_W = $clog2(MAX_LINE_BLOCKS + 1);
    localparam int BLK_W = (MLB_W > CFG_W) ? MLB_W : CFG_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_width, r_height;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [TBL_DEPTH-1:0] r_tbl_vld;
    logic [TBL_AW-1:0]    r_entry;
    logic [PIX_W-1:0]     r_pix;
    logic                 r_eol, r_eof;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 in_fire;
    logic                 pix_fire;
    logic                 load_fire;
    logic [BLK_W-1:0]     w_ext, w_m1;
    logic [CFG_W-1:0]     h_m1;
    logic [COL_W-1:0]     line_last;
    logic [ROW_W-1:0]     frame_last;
    logic                 eol, eof;
    logic                 ram_we;
    logic [TBL_AW-1:0]    ram_raddr;
    logic [Q_W-1:0]       ram_rdata;
    logic [Q_W-1:0]       q;
    logic [DVD_W-1:0]     dividend;
    logic                 div_start;
    t_div_status          div_stat;
    logic [Q_W-1:0]       div_quot;
    logic                 out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign pix_fire   = in_fire && (i_in_data.action == ACT_PIXEL);
    assign load_fire  = in_fire && (i_in_data.action == ACT_LOAD);
    assign ram_we     = load_fire && (i_in_data.entry_value != '0);

    // Geometry: zero means one block, clamp to limits, last position = 8*n-1
    always_comb begin
        w_ext = BLK_W'(r_width);
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (w_ext > BLK_W'(MAX_LINE_BLOCKS)) begin
            w_m1 = BLK_W'(MAX_LINE_BLOCKS - 1);
        end else begin
            w_m1 = w_ext - 1'b1;
        end
        if (r_height == '0) begin
            h_m1 = '0;
        end else if (r_height > CFG_W'(MAX_FRAME_BLOCKS)) begin
            h_m1 = CFG_W'(MAX_FRAME_BLOCKS - 1);
        end else begin
            h_m1 = r_height - 1'b1;
        end
        line_last  = {w_m1[COL_W-4:0], 3'b111};
        frame_last = {h_m1[ROW_W-4:0], 3'b111};
        eol        = r_col >= line_last;
        eof        = eol && (r_row >= frame_last);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(32);
            r_height <= CFG_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Position counters and table valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_tbl_vld <= '0;
        end else begin
            if (pix_fire) begin
                if (eol) begin
                    r_col <= '0;
                    r_row <= eof ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (ram_we) begin
                r_tbl_vld[i_in_data.entry_index] <= 1'b1;
            end
        end
    end

    // Pixel context captured at transfer
    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_entry <= ram_raddr;
            r_pix   <= i_in_data.pixel;
            r_eol   <= eol;
            r_eof   <= eof;
        end
    end

    // Divisor table storage; unwritten entries read as the luminance table
    assign ram_raddr = {r_row[2:0], r_col[2:0]};

    btq_ram #(
        .WIDTH (Q_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_data.entry_index),
        .i_wdata (i_in_data.entry_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Rounded dividend: pixel + q/2
    always_comb begin
        q         = r_tbl_vld[r_entry] ? ram_rdata : LUMA_TABLE[r_entry];
        dividend  = {1'b0, r_pix} + {2'b00, q[Q_W-1:1]};
        div_start = (r_state == S_FETCH);
    end

    btq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (q),
        .o_status   (div_stat),
        .o_quotient (div_quot)
    );

    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (pix_fire) n_state = S_FETCH;
            S_FETCH: n_state = S_DIV;
            S_DIV:   if (div_stat.done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.quantized    <= div_quot;
            r_out.end_of_line  <= r_eol;
            r_out.end_of_frame <= r_eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_pix_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_fire |=> !o_in_ready)
        else $error("input accepted while pixel in flight");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_no_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (q != '0))
        else $error("zero divisor reached the divider");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && o_out_valid && !i_out_ready) |=>
        (r_state == S_DONE && o_out_valid))
        else $error("result overwrote a pending output");

endmodule
